>>> rtl/limit_switch_monitor_macros.svh
// ----------------------------------------------------------------------------
// limit switch monitor assertion macros
// concurrent checks that vanish when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LIMIT_SWITCH_MONITOR_MACROS_SVH
`define LIMIT_SWITCH_MONITOR_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define LSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// shared types, switch bit positions and helpers of the limit switch monitor
// ----------------------------------------------------------------------------
package lsm_pkg;

  // switch vector and field widths
  localparam int unsigned SwW          = 13;
  localparam int unsigned SwIdxW       = 4;
  localparam int unsigned ZCntW        = 3;
  localparam int unsigned AxisW        = 3;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned MaxZSwitches = 4;

  // switch bit positions
  localparam int unsigned BitXMin     = 0;
  localparam int unsigned BitYMin     = 1;
  localparam int unsigned BitZMin     = 2;
  localparam int unsigned BitProbe    = 3;
  localparam int unsigned BitXMax     = 4;
  localparam int unsigned BitYMax     = 5;
  localparam int unsigned BitZMax     = 6;
  localparam int unsigned BitGangBase = 5;

  // stop_axes bit positions
  localparam int unsigned AxisX = 0;
  localparam int unsigned AxisY = 1;
  localparam int unsigned AxisZ = 2;

  // register reset values
  localparam logic [SwW-1:0]   PolarityReset = 13'h0000;
  localparam logic [SwW-1:0]   FittedReset   = 13'h007f;
  localparam logic [ZCntW-1:0] ZCountReset   = 3'd1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPolarity  = 3'd0,
    CfgFitted    = 3'd1,
    CfgZCount    = 3'd2,
    CfgProbeZmin = 3'd3,
    CfgG38       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [SwW-1:0]   polarity;
    logic [SwW-1:0]   fitted;
    logic [ZCntW-1:0] z_count;
    logic             probe_zmin;
    logic             g38;
  } cfg_t;

  typedef struct packed {
    logic [SwW-1:0] pin_levels;
    logic           x_moving;
    logic           y_moving;
    logic           z_moving;
    logic           x_toward_min;
    logic           y_toward_min;
    logic           z_toward_min;
    logic           homing_active;
    logic           probe_move;
    logic           probe_enabled;
    logic           clear_hits;
  } in_item_t;

  typedef struct packed {
    logic [AxisW-1:0] stop_axes;
    logic             kill_move;
    logic [SwW-1:0]   hit_record;
    logic             probe_hit;
  } result_t;

  // switch of ganged z unit k (1..3) at the min or max end
  function automatic logic [SwIdxW-1:0] gang_bit(input int unsigned k, input logic zneg);
    gang_bit = SwIdxW'(BitGangBase + 2 * k + (zneg ? 0 : 1));
  endfunction

  // pattern meaning all n ganged switches agree
  function automatic logic [MaxZSwitches-1:0] z_agree_mask(input logic [ZCntW-1:0] n);
    unique case (n)
      3'd2:    z_agree_mask = 4'h3;
      3'd3:    z_agree_mask = 4'h7;
      3'd4:    z_agree_mask = 4'hf;
      default: z_agree_mask = 4'h1;
    endcase
  endfunction

endpackage

>>> rtl/lsm_ifs.sv
// ----------------------------------------------------------------------------
// limit switch monitor channels
// valid/ready request, result and register write interfaces
// ----------------------------------------------------------------------------

// tick request channel
interface lsm_in_if;
  logic                      valid;
  logic                      ready;
  logic [lsm_pkg::SwW-1:0]   pin_levels;
  logic                      x_moving;
  logic                      y_moving;
  logic                      z_moving;
  logic                      x_toward_min;
  logic                      y_toward_min;
  logic                      z_toward_min;
  logic                      homing_active;
  logic                      probe_move;
  logic                      probe_enabled;
  logic                      clear_hits;

  modport source (
    output valid, pin_levels, x_moving, y_moving, z_moving, x_toward_min,
           y_toward_min, z_toward_min, homing_active, probe_move, probe_enabled,
           clear_hits,
    input  ready
  );
  modport sink (
    input  valid, pin_levels, x_moving, y_moving, z_moving, x_toward_min,
           y_toward_min, z_toward_min, homing_active, probe_move, probe_enabled,
           clear_hits,
    output ready
  );
endinterface

// result channel
interface lsm_out_if;
  logic                      valid;
  logic                      ready;
  logic [lsm_pkg::AxisW-1:0] stop_axes;
  logic                      kill_move;
  logic [lsm_pkg::SwW-1:0]   hit_record;
  logic                      probe_hit;

  modport source (output valid, stop_axes, kill_move, hit_record, probe_hit, input ready);
  modport sink   (input valid, stop_axes, kill_move, hit_record, probe_hit, output ready);
endinterface

// register write channel
interface lsm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lsm_pkg::CfgIdxW-1:0]  index;
  logic [lsm_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/lsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsm_cfg_regs
// configuration registers written through the register channel
// ----------------------------------------------------------------------------
module lsm_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  lsm_cfg_if.sink       cfg_if,
  output lsm_pkg::cfg_t cfg
);
  import lsm_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  // writes are always taken
  assign cfg_if.ready = 1'b1;
  assign wr_en        = cfg_if.valid && cfg_if.ready;
  assign cfg          = cfg_r;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polarity   <= PolarityReset;
      cfg_r.fitted     <= FittedReset;
      cfg_r.z_count    <= ZCountReset;
      cfg_r.probe_zmin <= 1'b0;
      cfg_r.g38        <= 1'b0;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(cfg_if.index))
        CfgPolarity:  cfg_r.polarity   <= cfg_if.data[SwW-1:0];
        CfgFitted:    cfg_r.fitted     <= cfg_if.data[SwW-1:0];
        CfgZCount:    cfg_r.z_count    <= cfg_if.data[ZCntW-1:0];
        CfgProbeZmin: cfg_r.probe_zmin <= cfg_if.data[0];
        CfgG38:       cfg_r.g38        <= cfg_if.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/lsm_in_stage.sv
// ----------------------------------------------------------------------------
// lsm_in_stage
// input register holding one tick request for evaluation
// ----------------------------------------------------------------------------
module lsm_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  lsm_in_if.sink            in_if,
  input  logic              advance,
  output logic              item_valid,
  output lsm_pkg::in_item_t item
);
  import lsm_pkg::*;

  logic     valid_r;
  in_item_t item_r;
  logic     accept;

  // free slot or the held request moves on this cycle
  assign in_if.ready = !valid_r || advance;
  assign accept      = in_if.valid && in_if.ready;
  assign item_valid  = valid_r;
  assign item        = item_r;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.pin_levels    <= in_if.pin_levels;
      item_r.x_moving      <= in_if.x_moving;
      item_r.y_moving      <= in_if.y_moving;
      item_r.z_moving      <= in_if.z_moving;
      item_r.x_toward_min  <= in_if.x_toward_min;
      item_r.y_toward_min  <= in_if.y_toward_min;
      item_r.z_toward_min  <= in_if.z_toward_min;
      item_r.homing_active <= in_if.homing_active;
      item_r.probe_move    <= in_if.probe_move;
      item_r.probe_enabled <= in_if.probe_enabled;
      item_r.clear_hits    <= in_if.clear_hits;
    end
  end

endmodule

>>> rtl/lsm_core.sv
// ----------------------------------------------------------------------------
// lsm_core
// switch sampling, debounce, stop and kill decisions and sticky hit record
// ----------------------------------------------------------------------------
`include "limit_switch_monitor_macros.svh"

module lsm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  lsm_pkg::in_item_t item,
  input  lsm_pkg::cfg_t     cfg,
  output lsm_pkg::result_t  res_nxt
);
  import lsm_pkg::*;

  // the previous sample always equals the last stored sample, so one
  // register serves as both current and previous sample
  logic [SwW-1:0]          smp_r;
  logic [SwW-1:0]          hits_r;

  logic [SwW-1:0]          act;
  logic [SwW-1:0]          take_m;
  logic [SwW-1:0]          copy_m;
  logic [SwW-1:0]          smp_nxt;
  logic [SwW-1:0]          trig;
  logic [SwW-1:0]          hits_nxt;
  logic [ZCntW-1:0]        zn;
  logic [SwIdxW-1:0]       bx;
  logic [SwIdxW-1:0]       by;
  logic [SwIdxW-1:0]       bz;
  logic                    g38_chk;
  logic                    z_main_ok;
  logic                    z_gang;
  logic                    z_single;
  logic                    zp_chk;
  logic [MaxZSwitches-1:0] ztest;
  logic [AxisW-1:0]        stop;
  logic                    kill;
  logic                    phit;

  // active levels, clamped z count and the switch each axis heads for
  always_comb begin
    act = item.pin_levels ^ cfg.polarity;
    if (cfg.z_count == '0) begin
      zn = ZCntW'(1);
    end else if (cfg.z_count > ZCntW'(MaxZSwitches)) begin
      zn = ZCntW'(MaxZSwitches);
    end else begin
      zn = cfg.z_count;
    end
    bx = item.x_toward_min ? SwIdxW'(BitXMin) : SwIdxW'(BitXMax);
    by = item.y_toward_min ? SwIdxW'(BitYMin) : SwIdxW'(BitYMax);
    bz = item.z_toward_min ? SwIdxW'(BitZMin) : SwIdxW'(BitZMax);
  end

  // which checks run this tick
  always_comb begin
    g38_chk   = cfg.g38 && item.probe_move && !cfg.probe_zmin && cfg.fitted[BitProbe];
    z_main_ok = item.z_moving && cfg.fitted[bz];
    z_gang    = z_main_ok && (zn >= ZCntW'(2));
    z_single  = z_main_ok && !z_gang
                && !(item.z_toward_min && cfg.probe_zmin && !item.probe_enabled);
    zp_chk    = item.z_moving && item.z_toward_min && !cfg.probe_zmin
                && cfg.fitted[BitProbe] && item.probe_enabled;
  end

  // switches sampled and ganged switches copied from the main z switch
  always_comb begin
    take_m = '0;
    copy_m = '0;
    if (g38_chk || zp_chk) begin
      take_m[BitProbe] = 1'b1;
    end
    if (item.x_moving && cfg.fitted[bx]) begin
      take_m[bx] = 1'b1;
    end
    if (item.y_moving && cfg.fitted[by]) begin
      take_m[by] = 1'b1;
    end
    if (z_gang || z_single) begin
      take_m[bz] = 1'b1;
    end
    for (int unsigned k = 1; k < MaxZSwitches; k++) begin
      if (z_gang && (k < int'(zn))) begin
        if (cfg.fitted[gang_bit(k, item.z_toward_min)]) begin
          take_m[gang_bit(k, item.z_toward_min)] = 1'b1;
        end else begin
          copy_m[gang_bit(k, item.z_toward_min)] = 1'b1;
        end
      end
    end
  end

  // new sample and two-sample trigger
  assign smp_nxt = (smp_r & ~(take_m | copy_m)) | (act & take_m)
                   | ({SwW{act[bz]}} & copy_m);
  assign trig    = smp_nxt & smp_r;

  // ganged z trigger pattern, bit 0 is the main switch
  always_comb begin
    ztest    = '0;
    ztest[0] = trig[bz];
    for (int unsigned k = 1; k < MaxZSwitches; k++) begin
      if (k < int'(zn)) begin
        ztest[k] = trig[gang_bit(k, item.z_toward_min)];
      end
    end
  end

  // stop, kill and hit record
  always_comb begin
    hits_nxt = item.clear_hits ? '0 : hits_r;
    stop     = '0;
    kill     = 1'b0;
    phit     = g38_chk && trig[BitProbe];
    // probe move stops the first moving axis
    if (phit) begin
      priority if (item.x_moving) begin
        hits_nxt[BitXMin] = 1'b1;
        stop[AxisX]       = 1'b1;
      end else if (item.y_moving) begin
        hits_nxt[BitYMin] = 1'b1;
        stop[AxisY]       = 1'b1;
      end else if (item.z_moving) begin
        hits_nxt[BitZMin] = 1'b1;
        stop[AxisZ]       = 1'b1;
      end else begin
        // no axis moving: only probe_hit is flagged
      end
    end
    if (item.x_moving && cfg.fitted[bx] && trig[bx]) begin
      hits_nxt[bx] = 1'b1;
      stop[AxisX]  = 1'b1;
    end
    if (item.y_moving && cfg.fitted[by] && trig[by]) begin
      hits_nxt[by] = 1'b1;
      stop[AxisY]  = 1'b1;
    end
    // ganged z: kill unless homing with switches in disagreement
    if (z_gang && (ztest != '0)) begin
      hits_nxt[BitZMin] = 1'b1;
      if (!item.homing_active || (ztest == z_agree_mask(zn))) begin
        kill = 1'b1;
      end
    end
    if (z_single && trig[bz]) begin
      hits_nxt[bz] = 1'b1;
      stop[AxisZ]  = 1'b1;
    end
    // probe on the way down
    if (zp_chk && trig[BitProbe]) begin
      hits_nxt[BitProbe] = 1'b1;
      stop[AxisZ]        = 1'b1;
    end
  end

  assign res_nxt.stop_axes  = stop;
  assign res_nxt.kill_move  = kill;
  assign res_nxt.hit_record = hits_nxt;
  assign res_nxt.probe_hit  = phit;

  // sample and hit state, updated once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r  <= '0;
      hits_r <= '0;
    end else if (advance) begin
      smp_r  <= smp_nxt;
      hits_r <= hits_nxt;
    end
  end

  `LSM_ASSERT_IMP(a_kill_records_z, clk, rst_n, advance && kill, hits_nxt[BitZMin],
                  "kill without z hit")
  `LSM_ASSERT_IMP(a_stop_records_hit, clk, rst_n, advance && (stop != '0), hits_nxt != '0,
                  "stop without hit")
  `LSM_ASSERT_NXT(a_hits_sticky, clk, rst_n, advance && !item.clear_hits,
                  (hits_r & $past(hits_r)) == $past(hits_r), "hit record lost a bit")

endmodule

>>> rtl/lsm_out_stage.sv
// ----------------------------------------------------------------------------
// lsm_out_stage
// result register driving the result channel
// ----------------------------------------------------------------------------
module lsm_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  lsm_pkg::result_t res_nxt,
  output logic             room,
  lsm_out_if.source        out_if
);
  import lsm_pkg::*;

  logic    valid_r;
  result_t res_r;

  // empty, or the held result leaves this cycle
  assign room              = !valid_r || out_if.ready;
  assign out_if.valid      = valid_r;
  assign out_if.stop_axes  = res_r.stop_axes;
  assign out_if.kill_move  = res_r.kill_move;
  assign out_if.hit_record = res_r.hit_record;
  assign out_if.probe_hit  = res_r.probe_hit;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> rtl/limit_switch_monitor.sv
// ----------------------------------------------------------------------------
// limit_switch_monitor
// per-tick end stop check: debounced switches stop axes, ganged z kills moves
// ----------------------------------------------------------------------------
//   channel  direction  handshake      payload
//   in_if    in         valid/ready    pin levels, motion flags, clear_hits
//   out_if   out        valid/ready    stop_axes, kill_move, hit_record, probe_hit
//   cfg_if   in         valid/ready    index, data (ready always high)
//
// one tick request per cycle unless out_if stalls; each request passes through
// the input register and then the result register
// reset clears samples, hit record, stage valids and loads register defaults
// a stalled result holds; the input register still takes one more request
// ----------------------------------------------------------------------------
`include "limit_switch_monitor_macros.svh"

module limit_switch_monitor (
  input  logic      clk,
  input  logic      rst_n,
  lsm_in_if.sink    in_if,
  lsm_out_if.source out_if,
  lsm_cfg_if.sink   cfg_if
);
  import lsm_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  result_t  res_nxt;
  logic     item_valid;
  logic     room;
  logic     advance;

  // request moves from input register to result register
  assign advance = item_valid && room;

  lsm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  lsm_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lsm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  lsm_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .res_nxt (res_nxt),
    .room    (room),
    .out_if  (out_if)
  );

  `LSM_ASSERT_IMP(a_flow_when_empty, clk, rst_n, item_valid && !out_if.valid, advance,
                  "request stuck with empty result register")
  `LSM_ASSERT_NXT(a_result_kept, clk, rst_n, out_if.valid && !out_if.ready, out_if.valid,
                  "stalled result dropped")

endmodule
